@@ rtl/core/xoshiro_bounded_random_defines.svh @@
// assertion macros used by the checker file
`ifndef XOSHIRO_BOUNDED_RANDOM_DEFINES_SVH
`define XOSHIRO_BOUNDED_RANDOM_DEFINES_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define XBR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet during reset
`define XBR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/xbr_pkg.sv @@
// shared types, codes and helper functions of the bounded xoshiro generator
package xbr_pkg;

   localparam int WORD_WIDTH      = 64;
   localparam int KIND_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_RAW    = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RANGE  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_RESEED = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_SECOND = 2'd1;

   localparam logic [WORD_WIDTH-1:0] RESEED_WORD1 = 64'h0000_0000_0000_00ff;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef enum logic [1:0] {
      OUT_BOUND,
      OUT_RAW,
      OUT_RANGE
   } out_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        reseed;
      logic        order;
      logic        span;
      logic        draw;
      logic        scramble;
      logic        load_out;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic bounds_equal;
      logic reject;
   } dp_status_type;

   function automatic word_type rotl(input word_type x, input int unsigned k);
      rotl = (x << k) | (x >> (WORD_WIDTH - k));
   endfunction

   // smallest all-ones value covering x
   function automatic word_type smear(input word_type x);
      word_type m;
      m = x;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      m = m | (m >> 32);
      smear = m;
   endfunction

endpackage

@@ rtl/core/xbr_ctrl.sv @@
// sequencer: accepts beats, steps the datapath and owns the result valid
module xbr_ctrl
   import xbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [KIND_WIDTH-1:0] req_kind,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dp_cmd_type            cmd,
   input  dp_status_type         status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ORDER,
      S_SPAN,
      S_DRAW,
      S_SCRAMBLE,
      S_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      is_range_ff, is_range_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      is_range_in = is_range_ff;
      cmd         = '0;
      cmd.out_sel = OUT_RAW;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               case (req_kind)
                  KIND_RAW: begin
                     is_range_in = 1'b0;
                     state_in    = S_DRAW;
                  end
                  KIND_RANGE: begin
                     is_range_in = 1'b1;
                     state_in    = S_ORDER;
                  end
                  KIND_RESEED: cmd.reseed = 1'b1;
                  default: ;
               endcase
            end
         end
         S_ORDER: begin
            if (status.bounds_equal) begin
               if (out_free) begin
                  cmd.load_out = 1'b1;
                  cmd.out_sel  = OUT_BOUND;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.order = 1'b1;
               state_in  = S_SPAN;
            end
         end
         S_SPAN: begin
            cmd.span = 1'b1;
            state_in = S_DRAW;
         end
         S_DRAW: begin
            cmd.draw = 1'b1;
            state_in = S_SCRAMBLE;
         end
         S_SCRAMBLE: begin
            cmd.scramble = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (is_range_ff && status.reject) begin
               state_in = S_DRAW;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = is_range_ff ? OUT_RANGE : OUT_RAW;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         is_range_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_range_ff  <= is_range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/xbr_datapath.sv @@
// generator state, seed registers, range arithmetic and the result register
module xbr_datapath
   import xbr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_data,
   input  logic signed [WORD_WIDTH-1:0] req_bound_a,
   input  logic signed [WORD_WIDTH-1:0] req_bound_b,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   output logic [WORD_WIDTH-1:0]      rsp_value
);

   word_type seed_first_ff, seed_second_ff;
   word_type word_ff [4];
   word_type word_in [4];
   word_type a_ff, b_ff, lo_ff, hi_ff, span_ff;
   word_type p_ff, p_in;
   word_type r_ff, r_in;
   word_type out_ff, out_in;
   word_type step0, step1, step2, step3, shifted, rot, mask, masked;

   // one xoshiro256** state advance
   always_comb begin
      shifted = word_ff[1] << 17;
      step2   = word_ff[2] ^ word_ff[0];
      step3   = word_ff[3] ^ word_ff[1];
      step1   = word_ff[1] ^ step2;
      step0   = word_ff[0] ^ step3;
   end

   always_comb begin
      if (cmd.reseed) begin
         word_in[0] = seed_first_ff;
         word_in[1] = RESEED_WORD1;
         word_in[2] = seed_second_ff;
         word_in[3] = '0;
      end else if (cmd.draw) begin
         word_in[0] = step0;
         word_in[1] = step1;
         word_in[2] = step2 ^ shifted;
         word_in[3] = rotl(step3, 45);
      end else begin
         word_in = word_ff;
      end
   end

   // scrambler split over two registers: times 5 into p_ff, then rotate and times 9 into r_ff
   assign p_in = word_ff[1] + (word_ff[1] << 2);
   assign rot  = rotl(p_ff, 7);
   assign r_in = rot + (rot << 3);

   assign mask   = smear(span_ff);
   assign masked = r_ff & mask;

   assign status.bounds_equal = (a_ff == b_ff);
   assign status.reject       = (masked > span_ff);

   always_comb begin
      case (cmd.out_sel)
         OUT_BOUND: out_in = a_ff;
         OUT_RAW:   out_in = r_ff;
         OUT_RANGE: out_in = masked + lo_ff;
         default:   out_in = r_ff;
      endcase
   end

   assign rsp_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_first_ff  <= '0;
         seed_second_ff <= '0;
         word_ff[0]     <= '0;
         word_ff[1]     <= RESEED_WORD1;
         word_ff[2]     <= '0;
         word_ff[3]     <= '0;
      end else begin
         if (csr_write && (csr_index == CSR_SEED_FIRST)) begin
            seed_first_ff <= csr_data;
         end
         if (csr_write && (csr_index == CSR_SEED_SECOND)) begin
            seed_second_ff <= csr_data;
         end
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         a_ff <= $unsigned(req_bound_a);
         b_ff <= $unsigned(req_bound_b);
      end
      if (cmd.order) begin
         if ($signed(a_ff) < $signed(b_ff)) begin
            lo_ff <= a_ff;
            hi_ff <= b_ff;
         end else begin
            lo_ff <= b_ff;
            hi_ff <= a_ff;
         end
      end
      if (cmd.span) begin
         span_ff <= hi_ff - lo_ff;
      end
      if (cmd.draw) begin
         p_ff <= p_in;
      end
      if (cmd.scramble) begin
         r_ff <= r_in;
      end
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

endmodule

@@ rtl/core/xoshiro_bounded_random.sv @@
// top level of the bounded xoshiro256** random generator
//
// Request channel (req_valid / req_stall) carries one beat per item: req_kind
// selects a raw 64-bit draw, a signed integer in [bound_a, bound_b] (either
// order), or a reseed from the two seed registers. The result channel
// (rsp_valid / rsp_stall) returns one beat for raw and range items, none for
// reseed or the unused kind. The user writes seeds through csr_write /
// csr_index / csr_data only while the block is idle; it does not enforce this.
// Sequence: a raw item runs the draw, scramble and check steps and then loads
// its result; the block takes a new item only once the previous one is done.
// A range item first runs the ordering and span steps, and each rejected draw
// repeats the draw, scramble and check sequence of the single generator unit;
// fewer than two draws are needed on average. Equal bounds answer from the
// ordering step. A reseed or unused kind leaves the block idle.
// Reset loads the generator with 0, 0xff, 0, 0 and clears both seeds.
// The result sits in an output register: a stalled receiver holds it there
// while the block already takes the next request; a finished result then
// waits in the last step until the register frees up.
module xoshiro_bounded_random
   import xbr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [WORD_WIDTH-1:0]        csr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [KIND_WIDTH-1:0]        req_kind,
   input  logic signed [WORD_WIDTH-1:0] req_bound_a,
   input  logic signed [WORD_WIDTH-1:0] req_bound_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [WORD_WIDTH-1:0]        rsp_value
);

   dp_cmd_type    cmd;
   dp_status_type status;

   xbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   xbr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_bound_a (req_bound_a),
      .req_bound_b (req_bound_b),
      .cmd         (cmd),
      .status      (status),
      .rsp_value   (rsp_value)
   );

endmodule

@@ rtl/core/xbr_checker.sv @@
// port-level checks of the bounded xoshiro generator, bound to the top level
`include "xoshiro_bounded_random_defines.svh"
module xbr_checker
   import xbr_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [KIND_WIDTH-1:0]        req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [WORD_WIDTH-1:0]        rsp_value
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // a stalled result beat holds
   `XBR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value), "stalled result beat changed")

   // raw and range items keep the block busy once accepted, so new requests stall
   `XBR_ASSERT_NEXT(a_busy_after_draw, req_beat && (req_kind == KIND_RAW || req_kind == KIND_RANGE), req_stall, "block free right after accepting a draw")

   // items without a result leave the block free
   `XBR_ASSERT_NEXT(a_free_after_reseed, req_beat && !(req_kind == KIND_RAW || req_kind == KIND_RANGE), !req_stall, "block busy after an item with no result")

   // a new result beat comes with the request side free again
   `XBR_ASSERT_NOW(a_done_frees, $rose(rsp_valid), !req_stall, "result issued while still busy")

endmodule

bind xoshiro_bounded_random xbr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_value (rsp_value)
);
